// File: rtl/core/pdke_pkg.sv
// Shared constants, register indices and batch control type of the k-mer extractor.
package pdke_pkg;

	localparam int DEF_MAX_KMER   = 16;
	localparam int BASES_PER_BYTE = 4;
	localparam int BASE_W         = 2;
	localparam int BYTE_W         = BASES_PER_BYTE * BASE_W;
	localparam int CFG_W          = 32;
	localparam int POS_W          = 32;
	localparam int CODE_W         = 32;
	localparam int KLEN_W         = 5;
	localparam int KMER_RESET     = 16;
	// k-mers left to emit: up to 2^32 - 1, held in one bit more than a position
	localparam int REM_W          = POS_W + 1;

	typedef enum logic [1:0] {
		REG_KMER_LENGTH     = 2'd0,
		REG_START_POSITION  = 2'd1,
		REG_SEQUENCE_LENGTH = 2'd2
	} cfg_reg_t;

	// One byte's worth of results handed from the window stage to the emitter
	typedef struct packed {
		logic [1:0]       cnt_m1;  // results in the batch, minus one
		logic             last;    // final result of the batch ends the scan
		logic [POS_W-1:0] pos;     // position of the first result of the batch
	} bat_ctl_t;

endpackage

// File: rtl/core/packed_dna_kmer_extractor_top.sv
// Top level of the packed DNA k-mer extractor: configuration registers and rearm logic.
//
// Takes one packed byte (four 2-bit bases, earliest base in bits 1:0) per transfer and
// emits every k-mer of the configured range with its position and a last flag. A byte
// that yields no k-mer (warm-up, or any byte after the final k-mer) does not hold the
// emitter; a byte that yields n k-mers (1 to 4) holds it until all n are sent, since the
// single result port sends one k-mer per cycle while out_ready allows. The next byte is
// taken in the cycle the emitter starts on the last k-mer of the current one. Results
// pass through the batch register and then the output register. Writing any of the
// three registers rearms the block for a new sequence; write only while the block is
// idle. The block comes out of reset rearmed with the reset register values, so it
// emits nothing until a sequence length is written.
module packed_dna_kmer_extractor_top #(
	parameter int MAX_KMER = pdke_pkg::DEF_MAX_KMER
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration
	input  logic                         cfg_we,
	input  logic [1:0]                   cfg_index,
	input  logic [pdke_pkg::CFG_W-1:0]   cfg_wdata,
	// byte channel
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [pdke_pkg::BYTE_W-1:0]  packed_byte,
	// result channel
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [pdke_pkg::CODE_W-1:0]  kmer_code,
	output logic [pdke_pkg::POS_W-1:0]   kmer_position,
	output logic                         last_kmer
);
	import pdke_pkg::*;

	localparam int KW = $clog2(MAX_KMER + 1);
	localparam int PW = $clog2(MAX_KMER + 4);
	localparam int JW = $clog2(MAX_KMER + 4);
	localparam int WW = 2 * (MAX_KMER + 4);

	logic [KLEN_W-1:0] klen_q;
	logic [POS_W-1:0]  start_q;
	logic [POS_W-1:0]  len_q;

	logic [KLEN_W-1:0] klen_n;
	logic [POS_W-1:0]  start_n;
	logic [POS_W-1:0]  len_n;
	logic              arm;
	logic [KW-1:0]     arm_k;
	logic [PW-1:0]     arm_pre;
	logic [REM_W-1:0]  arm_rem;

	logic              bat_vld;
	logic [WW-1:0]     bat_win;
	logic [JW-1:0]     bat_j;
	bat_ctl_t          bat_ctl;
	logic              bat_take;
	logic [KW-1:0]     k_eff;

	// Register values as they stand after this cycle's write
	always_comb begin
		klen_n  = klen_q;
		start_n = start_q;
		len_n   = len_q;
		arm     = 1'b0;
		if (cfg_we) begin
			unique case (cfg_index)
				REG_KMER_LENGTH: begin
					klen_n = cfg_wdata[KLEN_W-1:0];
					arm    = 1'b1;
				end
				REG_START_POSITION: begin
					start_n = cfg_wdata[POS_W-1:0];
					arm     = 1'b1;
				end
				REG_SEQUENCE_LENGTH: begin
					len_n = cfg_wdata[POS_W-1:0];
					arm   = 1'b1;
				end
				default: begin
					arm = 1'b0;
				end
			endcase
		end
	end

	// Clamp k to 1..MAX_KMER and derive the scan counters for the rearm
	always_comb begin
		priority if (klen_n == '0) begin
			arm_k = KW'(1);
		end else if ({1'b0, klen_n} > (KLEN_W + 1)'(MAX_KMER)) begin
			arm_k = KW'(MAX_KMER);
		end else begin
			arm_k = KW'(klen_n);
		end
		arm_pre = PW'(start_n[1:0]) + PW'(arm_k) - PW'(1);
		if (len_n >= POS_W'(arm_k)) begin
			arm_rem = {1'b0, len_n} - REM_W'(arm_k) + REM_W'(1);
		end else begin
			arm_rem = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			klen_q  <= KLEN_W'(KMER_RESET);
			start_q <= '0;
			len_q   <= '0;
		end else begin
			klen_q  <= klen_n;
			start_q <= start_n;
			len_q   <= len_n;
		end
	end

	pdke_window #(
		.MAX_KMER (MAX_KMER),
		.KW       (KW),
		.PW       (PW),
		.JW       (JW),
		.WW       (WW)
	) u_window (
		.clk         (clk),
		.arst_n      (arst_n),
		.arm         (arm),
		.arm_k       (arm_k),
		.arm_pre     (arm_pre),
		.arm_rem     (arm_rem),
		.arm_pos     (start_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.packed_byte (packed_byte),
		.bat_vld     (bat_vld),
		.bat_win     (bat_win),
		.bat_j       (bat_j),
		.bat_ctl     (bat_ctl),
		.bat_take    (bat_take),
		.k_eff       (k_eff)
	);

	pdke_emit #(
		.MAX_KMER (MAX_KMER),
		.KW       (KW),
		.JW       (JW),
		.WW       (WW)
	) u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.bat_vld       (bat_vld),
		.bat_win       (bat_win),
		.bat_j         (bat_j),
		.bat_ctl       (bat_ctl),
		.bat_take      (bat_take),
		.k_eff         (k_eff),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.kmer_code     (kmer_code),
		.kmer_position (kmer_position),
		.last_kmer     (last_kmer)
	);

endmodule

// File: rtl/core/pdke_window.sv
// Base window, scan counters and per-byte batch register of the k-mer extractor.
module pdke_window #(
	parameter int MAX_KMER = pdke_pkg::DEF_MAX_KMER,
	parameter int KW       = $clog2(MAX_KMER + 1),
	parameter int PW       = $clog2(MAX_KMER + 4),
	parameter int JW       = $clog2(MAX_KMER + 4),
	parameter int WW       = 2 * (MAX_KMER + 4)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// rearm
	input  logic                         arm,
	input  logic [KW-1:0]                arm_k,
	input  logic [PW-1:0]                arm_pre,
	input  logic [pdke_pkg::REM_W-1:0]   arm_rem,
	input  logic [pdke_pkg::POS_W-1:0]   arm_pos,
	// byte channel
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [pdke_pkg::BYTE_W-1:0]  packed_byte,
	// batch to the emitter
	output logic                         bat_vld,
	output logic [WW-1:0]                bat_win,
	output logic [JW-1:0]                bat_j,
	output pdke_pkg::bat_ctl_t           bat_ctl,
	input  logic                         bat_take,
	output logic [KW-1:0]                k_eff
);
	import pdke_pkg::*;

	localparam int K_RST = (KMER_RESET > MAX_KMER) ? MAX_KMER : KMER_RESET;

	logic [WW-1:0]    win_q;
	logic [KW-1:0]    k_q;
	logic [PW-1:0]    pre_q;
	logic [REM_W-1:0] rem_q;
	logic [POS_W-1:0] pos_q;

	logic             bat_vld_q;
	logic [WW-1:0]    bat_win_q;
	logic [JW-1:0]    bat_j_q;
	bat_ctl_t         bat_ctl_q;

	logic             in_xfer;
	logic [WW-1:0]    win_n;
	logic [2:0]       skip;
	logic [2:0]       avail;
	logic [2:0]       emit_n;
	logic [JW-1:0]    first_j;

	assign in_ready = !bat_vld_q || bat_take;
	assign in_xfer  = in_valid && in_ready;

	// Shift the four new bases in at the top of the window
	assign win_n = {packed_byte, win_q[WW-1:BYTE_W]};

	// Drop candidates that start before the start position, cap by k-mers left
	always_comb begin
		if (pre_q >= PW'(BASES_PER_BYTE)) begin
			skip = 3'(BASES_PER_BYTE);
		end else begin
			skip = 3'(pre_q);
		end
		avail = 3'(BASES_PER_BYTE) - skip;
		if (rem_q < REM_W'(avail)) begin
			emit_n = 3'(rem_q);
		end else begin
			emit_n = avail;
		end
		first_j = JW'(MAX_KMER + 1) - JW'(k_q) + JW'(skip);
	end

	// Scan state: window and counters advance on each byte transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
			k_q   <= KW'(K_RST);
			pre_q <= PW'(K_RST - 1);
			rem_q <= '0;
			pos_q <= '0;
		end else if (arm) begin
			win_q <= '0;
			k_q   <= arm_k;
			pre_q <= arm_pre;
			rem_q <= arm_rem;
			pos_q <= arm_pos;
		end else if (in_xfer) begin
			win_q <= win_n;
			pre_q <= pre_q - PW'(skip);
			rem_q <= rem_q - REM_W'(emit_n);
			pos_q <= pos_q + POS_W'(emit_n);
		end
	end

	// Batch register: hold one byte's results until the emitter has sent them all
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bat_vld_q <= 1'b0;
		end else if (in_xfer && emit_n != 3'd0) begin
			bat_vld_q <= 1'b1;
		end else if (bat_take) begin
			bat_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && emit_n != 3'd0) begin
			bat_win_q        <= win_n;
			bat_j_q          <= first_j;
			bat_ctl_q.cnt_m1 <= 2'(emit_n - 3'd1);
			bat_ctl_q.last   <= (rem_q == REM_W'(emit_n));
			bat_ctl_q.pos    <= pos_q;
		end
	end

	assign bat_vld = bat_vld_q;
	assign bat_win = bat_win_q;
	assign bat_j   = bat_j_q;
	assign bat_ctl = bat_ctl_q;
	assign k_eff   = k_q;

	// k-mers left only shrink between rearms
	a_rem_down: assert property (@(posedge clk) disable iff (!arst_n)
		!arm |=> rem_q <= $past(rem_q))
		else $error("k-mer count grew without rearm");

	// Warm-up skip count only shrinks between rearms
	a_pre_down: assert property (@(posedge clk) disable iff (!arst_n)
		!arm |=> pre_q <= $past(pre_q))
		else $error("skip count grew without rearm");

	// Position advances by exactly the number of k-mers handed out
	a_pos_track: assert property (@(posedge clk) disable iff (!arst_n)
		!arm |=> (pos_q - $past(pos_q)) == POS_W'($past(rem_q) - rem_q))
		else $error("position and k-mer count out of step");

endmodule

// File: rtl/core/pdke_emit.sv
// Result emitter of the k-mer extractor: one k-mer per cycle into the output register while it has a free slot.
module pdke_emit #(
	parameter int MAX_KMER = pdke_pkg::DEF_MAX_KMER,
	parameter int KW       = $clog2(MAX_KMER + 1),
	parameter int JW       = $clog2(MAX_KMER + 4),
	parameter int WW       = 2 * (MAX_KMER + 4)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         bat_vld,
	input  logic [WW-1:0]                bat_win,
	input  logic [JW-1:0]                bat_j,
	input  pdke_pkg::bat_ctl_t           bat_ctl,
	output logic                         bat_take,
	input  logic [KW-1:0]                k_eff,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [pdke_pkg::CODE_W-1:0]  kmer_code,
	output logic [pdke_pkg::POS_W-1:0]   kmer_position,
	output logic                         last_kmer
);
	import pdke_pkg::*;

	localparam int CW = 2 * MAX_KMER;
	localparam int TW = (CW > CODE_W) ? CW : CODE_W;

	logic [1:0]        idx_q;
	logic              out_valid_q;
	logic [CODE_W-1:0] code_q;
	logic [POS_W-1:0]  pos_q;
	logic              last_q;

	logic              out_load;
	logic              fire;
	logic [JW-1:0]     j;
	logic [WW-1:0]     shifted;
	logic [CW-1:0]     kmask;
	logic [CW-1:0]     kbits;
	logic [TW-1:0]     code_w;
	logic              idx_end;

	assign out_load = !out_valid_q || out_ready;
	assign fire     = bat_vld && out_load;
	assign idx_end  = (idx_q == bat_ctl.cnt_m1);
	assign bat_take = fire && idx_end;

	// Pick the k bases that start at window index j
	assign j       = bat_j + JW'(idx_q);
	assign shifted = bat_win >> {j, 1'b0};
	assign kmask   = {CW{1'b1}} >> ((KW + 1)'(CW) - {k_eff, 1'b0});
	assign kbits   = shifted[CW-1:0] & kmask;
	assign code_w  = TW'(kbits);

	// Step through the batch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (bat_take) begin
			idx_q <= '0;
		end else if (fire) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	// Output register: load on a free slot, clear after the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			code_q <= code_w[CODE_W-1:0];
			pos_q  <= bat_ctl.pos + POS_W'(idx_q);
			last_q <= bat_ctl.last && idx_end;
		end
	end

	assign out_valid     = out_valid_q;
	assign kmer_code     = code_q;
	assign kmer_position = pos_q;
	assign last_kmer     = last_q;

	// A batch is released only while one is held
	a_take_vld: assert property (@(posedge clk) disable iff (!arst_n)
		bat_take |-> bat_vld)
		else $error("batch released while none held");

	// A batch step is always followed by a result on the output
	a_fire_out: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid)
		else $error("result lost between batch and output register");

	// Step index never runs past the batch size
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		bat_vld |-> idx_q <= bat_ctl.cnt_m1)
		else $error("batch index beyond batch size");

endmodule
